// ----- sv/nmi_pkg.sv -----
// Shared types and constants of the normal matrix inverse transpose block.
package nmi_pkg;
  localparam int unsigned NumElem = 9;
  localparam int unsigned ElemW = 16;
  localparam int unsigned CofMagW = 32;
  localparam int unsigned DetMagW = 48;
  localparam int unsigned QuotW = 33;
  localparam int unsigned OutW = 32;
  localparam int unsigned FrontLat = 4;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [CofMagW-1:0] cof_mag_t;
  typedef logic [DetMagW-1:0] det_mag_t;
  typedef logic [QuotW-1:0] quot_t;

  typedef struct packed {
    det_mag_t dmag;
    logic singular;
    logic [NumElem-1:0] neg;
    logic [NumElem-1:0][CofMagW-1:0] cof_mag;
  } front_out_t;
endpackage

// ----- sv/nmi_front.sv -----
// Cofactor, determinant and singularity stages of the normal matrix block.
module nmi_front (
  input  logic                clk,
  input  logic                en,
  input  nmi_pkg::elem_t      m [9],
  input  nmi_pkg::det_mag_t   min_abs_det,
  output nmi_pkg::front_out_t fo
);
  import nmi_pkg::*;

  localparam logic [3:0] IA [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam logic [3:0] IB [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam logic [3:0] IC [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] ID [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  logic signed [31:0] pa_r [9];
  logic signed [31:0] pb_r [9];
  elem_t              a0_r1 [3];
  logic signed [32:0] cof_r2 [9];
  elem_t              a0_r2 [3];
  logic signed [32:0] cof_r3 [9];
  logic signed [48:0] dp_r3 [3];
  logic signed [49:0] det;
  logic signed [49:0] det_abs;
  logic signed [32:0] cabs [9];
  front_out_t         fo_nxt;
  front_out_t         fo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) begin
        pa_r[j] <= m[IA[j]] * m[IB[j]];
        pb_r[j] <= m[IC[j]] * m[ID[j]];
        cof_r2[j] <= 33'(pa_r[j]) - 33'(pb_r[j]);
        cof_r3[j] <= cof_r2[j];
      end
      for (int k = 0; k < 3; k++) begin
        a0_r1[k] <= m[k];
        a0_r2[k] <= a0_r1[k];
        dp_r3[k] <= 49'(a0_r2[k]) * 49'(cof_r2[k]);
      end
      fo_r <= fo_nxt;
    end
  end

  always_comb begin
    det = 50'(dp_r3[0]) + 50'(dp_r3[1]) + 50'(dp_r3[2]);
    det_abs = det[49] ? -det : det;
    fo_nxt.dmag = det_abs[DetMagW-1:0];
    fo_nxt.singular = (fo_nxt.dmag == '0) || (fo_nxt.dmag < min_abs_det);
    for (int j = 0; j < 9; j++) begin
      cabs[j] = cof_r3[j][32] ? -cof_r3[j] : cof_r3[j];
      fo_nxt.cof_mag[j] = cabs[j][CofMagW-1:0];
      fo_nxt.neg[j] = cof_r3[j][32] ^ det[49];
    end
  end

  assign fo = fo_r;
endmodule

// ----- sv/nmi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module nmi_div #(
  parameter int unsigned SHIFT = 28
) (
  input  logic              clk,
  input  logic              en,
  input  nmi_pkg::cof_mag_t num,
  input  nmi_pkg::det_mag_t den,
  input  logic              neg,
  output nmi_pkg::quot_t    quot,
  output logic              ovf,
  output logic              neg_o
);
  import nmi_pkg::*;

  localparam int unsigned NW = CofMagW + SHIFT;
  localparam int unsigned HW = NW - QuotW;

  logic [NW-1:0]      nfull;
  logic [HW-1:0]      nhi;
  logic [QuotW-1:0]   nlo_r [QuotW+1];
  det_mag_t           rem_r [QuotW+1];
  det_mag_t           den_r [QuotW+1];
  quot_t              q_r   [QuotW+1];
  logic [QuotW:0]     ovf_r;
  logic [QuotW:0]     neg_r;

  assign nfull = {num, SHIFT'(0)};
  assign nhi = nfull[NW-1:QuotW];

  always_ff @(posedge clk) begin
    if (en) begin
      nlo_r[0] <= nfull[QuotW-1:0];
      rem_r[0] <= DetMagW'(nhi);
      den_r[0] <= den;
      q_r[0] <= '0;
      ovf_r[0] <= DetMagW'(nhi) >= den;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [DetMagW:0] t;
    logic             ge;
    assign t = {rem_r[k], nlo_r[k][QuotW-1-k]};
    assign ge = t >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        nlo_r[k+1] <= nlo_r[k];
        rem_r[k+1] <= ge ? DetMagW'(t - {1'b0, den_r[k]}) : t[DetMagW-1:0];
        den_r[k+1] <= den_r[k];
        q_r[k+1] <= {q_r[k][QuotW-2:0], ge};
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign quot = q_r[QuotW];
  assign ovf = ovf_r[QuotW];
  assign neg_o = neg_r[QuotW];
endmodule

// ----- sv/normal_matrix_inverse_transpose.sv -----
// Top level of the normal matrix (inverse transpose) block.
// One 3x3 matrix transaction is accepted per clock cycle. Four stages form the
// cofactors, the determinant and the singular decision, and nine 34-stage
// divider pipelines (setup plus one quotient bit per stage) form the
// quotients, followed by the output register.
// All stages advance together; while a result waits on out_tready the whole
// pipeline holds and in_tready is low.
module normal_matrix_inverse_transpose #(
  parameter int unsigned IN_FRAC_BITS  = 12,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // n00, n01, n02, n10, n11, n12, n20, n21, n22
  output logic [1:0]   out_tuser,  // singular, saturated
  input  logic         cfg_wr_en,
  input  logic [47:0]  cfg_wr_data
);
  import nmi_pkg::*;

  localparam int unsigned DivLat = QuotW + 1;
  localparam int unsigned Lat = FrontLat + DivLat;

  logic               en;
  elem_t              m [9];
  det_mag_t           thr_r;
  front_out_t         fo;
  quot_t              q [9];
  logic [8:0]         ovf;
  logic [8:0]         neg;
  logic [Lat-1:0]     vld_r;
  logic [DivLat-1:0]  sing_r;
  logic               out_valid_r;
  logic [287:0]       out_data_r;
  logic [287:0]       out_data_nxt;
  logic [1:0]         out_user_r;
  logic [1:0]         out_user_nxt;
  logic               big;
  logic               any_sat;

  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  for (genvar j = 0; j < 9; j++) begin : g_unpack
    assign m[j] = in_tdata[j*ElemW +: ElemW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 48'd1;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  nmi_front u_front (
    .clk         (clk),
    .en          (en),
    .m           (m),
    .min_abs_det (thr_r),
    .fo          (fo)
  );

  for (genvar j = 0; j < 9; j++) begin : g_div
    nmi_div #(.SHIFT(IN_FRAC_BITS + OUT_FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en),
      .num   (fo.cof_mag[j]),
      .den   (fo.dmag),
      .neg   (fo.neg[j]),
      .quot  (q[j]),
      .ovf   (ovf[j]),
      .neg_o (neg[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[DivLat-2:0], fo.singular};
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_tvalid};
      out_valid_r <= vld_r[Lat-1];
    end
  end

  always_comb begin
    any_sat = 1'b0;
    big = 1'b0;
    out_data_nxt = '0;
    for (int j = 0; j < 9; j++) begin
      if (neg[j]) begin
        big = ovf[j] || (q[j] > 33'h080000000);
        out_data_nxt[j*OutW +: OutW] = big ? 32'h80000000 : OutW'(33'd0 - q[j]);
      end else begin
        big = ovf[j] || (q[j] > 33'h07FFFFFFF);
        out_data_nxt[j*OutW +: OutW] = big ? 32'h7FFFFFFF : q[j][OutW-1:0];
      end
      any_sat = any_sat | big;
    end
    if (sing_r[DivLat-1]) begin
      out_data_nxt = '0;
      out_user_nxt = 2'b01;
    end else begin
      out_user_nxt = {any_sat, 1'b0};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule

// ----- sv/nmi_checker.sv -----
// Port-level checker for the normal matrix block, bound to its top level.
module nmi_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [287:0] out_tdata,
  input logic [1:0]   out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("singular result not cleared");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind normal_matrix_inverse_transpose nmi_checker u_nmi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/nmi_checker.sv -----
// Checker that predicts normal matrix results and compares them with the block's output.
`timescale 1ns / 100ps
module nmi_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [47:0]  cfg_wr_data,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);
  localparam int ExpDepth = 64;

  typedef struct {
    logic [287:0] elems;
    logic [1:0]   flags;
  } normal_t;

  normal_t expected_normals [ExpDepth];
  int wr_ptr;
  int rd_ptr;
  logic [47:0] det_floor;

  function automatic logic [63:0] quotient_capped(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = 0;
    quo = 0;
    for (int i = 63; i >= -28; i--) begin
      rem = {rem[62:0], (i >= 0) ? num[i] : 1'b0};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
      if (quo > 64'h1_0000_0000) quo = 64'h1_0000_0000;
    end
    return quo;
  endfunction

  function automatic normal_t predict_normal(logic [143:0] mat, logic [47:0] floor_val);
    normal_t res;
    longint a[9];
    longint cof[9];
    longint det;
    logic [63:0] dmag;
    logic [63:0] q;
    logic [31:0] v;
    logic sat;
    logic neg;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(mat[16*i +: 16]));
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[5] * a[6] - a[3] * a[8];
    cof[2] = a[3] * a[7] - a[4] * a[6];
    cof[3] = a[2] * a[7] - a[1] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[1] * a[6] - a[0] * a[7];
    cof[6] = a[1] * a[5] - a[2] * a[4];
    cof[7] = a[2] * a[3] - a[0] * a[5];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
    dmag = (det < 0) ? -det : det;
    res.elems = '0;
    sat = 1'b0;
    if (dmag == 0 || dmag < {16'd0, floor_val}) begin
      res.flags = 2'b01;
      return res;
    end
    for (int j = 0; j < 9; j++) begin
      neg = (cof[j] < 0) != (det < 0);
      q = quotient_capped((cof[j] < 0) ? -cof[j] : cof[j], dmag);
      if (neg) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          sat = 1'b1;
        end
        v = 32'(-q);
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        v = q[31:0];
      end
      res.elems[32*j +: 32] = v;
    end
    res.flags = {sat, 1'b0};
    return res;
  endfunction

  assign pending_count = wr_ptr - rd_ptr;

  always @(posedge clk) begin
    normal_t exp_n;
    int errs;
    errs = 0;
    if (!rst_n) begin
      det_floor <= 48'd1;
      fail_count <= 0;
      result_count <= 0;
      wr_ptr <= 0;
      rd_ptr <= 0;
    end else begin
      if (cfg_wr_en) det_floor <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        expected_normals[wr_ptr % ExpDepth] <= predict_normal(in_tdata, det_floor);
        wr_ptr <= wr_ptr + 1;
      end
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (wr_ptr == rd_ptr) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          exp_n = expected_normals[rd_ptr % ExpDepth];
          rd_ptr <= rd_ptr + 1;
          for (int j = 0; j < 9; j++)
            if (out_tdata[32*j +: 32] !== exp_n.elems[32*j +: 32]) begin
              $error("n%0d%0d expected %h actual %h", j / 3, j % 3,
                     exp_n.elems[32*j +: 32], out_tdata[32*j +: 32]);
              errs++;
            end
          if (out_tuser[0] !== exp_n.flags[0]) begin
            $error("singular expected %b actual %b", exp_n.flags[0], out_tuser[0]);
            errs++;
          end
          if (out_tuser[1] !== exp_n.flags[1]) begin
            $error("saturated expected %b actual %b", exp_n.flags[1], out_tuser[1]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top that drives matrices and thresholds into the block and reports the verdict.
`timescale 1ns / 100ps
module tb_top;
  localparam int Latency = 39;
  localparam longint CycleLimit = 400000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_wr_en;
  logic [47:0]  cfg_wr_data;
  int           fail_count;
  int           pending_count;
  int           result_count;
  int           stall_pct;
  longint       cycle_count = 0;

  normal_matrix_inverse_transpose uut (.*);

  nmi_scoreboard checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [15:0] rand_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($signed($urandom_range(600)) - 300);
    endcase
  endfunction

  task automatic send_matrix(logic [143:0] mat, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= mat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipe;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
  endtask

  task automatic write_floor(logic [47:0] val);
    drain_pipe();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [143:0] random_matrix();
    logic [143:0] m;
    int mode;
    mode = $urandom_range(2);
    for (int i = 0; i < 9; i++) m[16*i +: 16] = rand_elem(mode);
    if ($urandom_range(9) == 0) m[127:96] = m[31:0];
    if ($urandom_range(19) == 0) m[143:0] = {m[143:48], 48'd0};
    return m;
  endfunction

  initial begin
    logic [143:0] m;
    int idle_pct;
    logic [47:0] floors[4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity, scaled identity, extremes, singular and near-singular matrices.
    send_matrix({16'h1000, 48'd0, 16'h1000, 48'd0, 16'h1000}, 0);
    send_matrix({16'h0001, 48'd0, 16'h0001, 48'd0, 16'h0001}, 0);
    send_matrix({16'h7FFF, 48'd0, 16'h7FFF, 48'd0, 16'h7FFF}, 0);
    send_matrix({16'h8000, 48'd0, 16'h8000, 48'd0, 16'h8000}, 0);
    send_matrix({9{16'h8000}}, 0);
    send_matrix({9{16'h7FFF}}, 0);
    send_matrix({9{16'hFFFF}}, 0);
    send_matrix('0, 0);
    send_matrix({16'h7FFF, 16'h8000, 16'h0001, 16'h0001, 16'h7FFF, 16'h8000,
                 16'h8000, 16'h0001, 16'h7FFF}, 0);
    send_matrix({16'hF000, 48'd0, 16'h1000, 48'd0, 16'h1000}, 0);
    send_matrix({16'h0001, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000,
                 16'h0001, 16'h0000, 16'h0002}, 0);
    for (int i = 0; i < 6; i++) send_matrix(random_matrix(), 0);
    write_floor(48'd0);
    send_matrix('0, 0);
    send_matrix({16'h0001, 48'd0, 16'h0001, 48'd0, 16'h0001}, 0);
    write_floor(48'hFFFF_FFFF_FFFF);
    send_matrix({16'h7FFF, 48'd0, 16'h7FFF, 48'd0, 16'h7FFF}, 0);
    send_matrix({16'h8000, 48'd0, 16'h8000, 48'd0, 16'h8000}, 0);

    floors[0] = 48'd1;
    floors[1] = 48'd0;
    floors[2] = 48'h10_0000_0000;
    floors[3] = 48'hFFFF_FFFF_FFFF;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0)
        write_floor((phase == 6) ? 48'($urandom) << 12 : floors[phase / 2]);
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 82; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 82; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < 216; n++) begin
        if (n == 100) drain_pipe();
        m = random_matrix();
        send_matrix(m, idle_pct);
      end
    end
    stall_pct = 0;
    drain_pipe();
    $display("Covered %0d results over four thresholds with sender and receiver idling.",
             result_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
